// ===== src/dtpb_pkg.sv =====
// Shared types and constants for the depth-tested pixel buffer.
`default_nettype none

package dtpb_pkg;

  // Default sizes of the store
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam int DEPTH_BITS_DEF = 16;

  // Entries in each queue between front, back and result port
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_VIEW_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_VIEW_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PEN_COLOR   = 2'd2;

  // Configuration reset values
  localparam logic [8:0] VIEW_WIDTH_RST  = 9'd256;
  localparam logic [7:0] VIEW_HEIGHT_RST = 8'd128;
  localparam logic [3:0] PEN_COLOR_RST   = 4'd0;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PLOT  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // One result beat
  typedef struct packed {
    logic       plot_written;
    logic [7:0] attribute;
    logic       in_range;
  } result_t;

endpackage

`default_nettype wire

// ===== src/dtpb_fifo.sv =====
// Small synchronous queue used between the front, the back and the result port.
`default_nettype none

module dtpb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dtpb_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);
  import dtpb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== src/dtpb_front.sv =====
// Front end: bounds test, row-offset multiply and depth saturation.
`default_nettype none

module dtpb_front #(
  parameter int MAX_WIDTH  = dtpb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtpb_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dtpb_pkg::DEPTH_BITS_DEF,
  parameter int AW         = 15
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire logic [1:0]             req_type,
  input  wire logic [9:0]             x_coord,
  input  wire logic [9:0]             y_coord,
  input  wire logic signed [15:0]     depth_in,
  input  wire logic [8:0]             view_width,
  input  wire logic [7:0]             view_height,
  output logic                        ready,
  input  wire logic                   q_full,
  output logic                        q_push,
  output logic [1:0]                  cmd_req,
  output logic                        cmd_in_range,
  output logic [AW-1:0]               cmd_idx,
  output logic signed [DEPTH_BITS-1:0] cmd_depth
);
  import dtpb_pkg::*;

  localparam logic [10:0] MAX_W = 11'(MAX_WIDTH);
  localparam logic [10:0] MAX_H = 11'(MAX_HEIGHT);
  localparam logic signed [31:0] D_HI = 32'((64'd1 << (DEPTH_BITS - 1)) - 64'd1);
  localparam logic signed [31:0] D_LO = -D_HI - 32'sd1;

  logic        valid_r, valid_nxt;
  logic [1:0]  req_r;
  logic        range_r;
  logic [AW-1:0] prod_r;
  logic [9:0]  x_r;
  logic signed [DEPTH_BITS-1:0] depth_r;

  logic [10:0] w_eff, h_eff;
  logic        on_screen;
  logic [20:0] prod_full;
  logic [20:0] idx_sum;
  logic signed [31:0] d_ext, d_sat;

  // Effective screen and strict bounds
  always_comb begin
    w_eff     = ({2'b00, view_width} < MAX_W) ? {2'b00, view_width} : MAX_W;
    h_eff     = ({3'b000, view_height} < MAX_H) ? {3'b000, view_height} : MAX_H;
    on_screen = ({1'b0, x_coord} < w_eff) && ({1'b0, y_coord} < h_eff);
  end

  // Row offset; x is added after the register
  assign prod_full = 21'(y_coord) * 21'(w_eff);

  // Saturate depth to the stored width
  always_comb begin
    d_ext = 32'(depth_in);
    if (d_ext > D_HI) begin
      d_sat = D_HI;
    end else if (d_ext < D_LO) begin
      d_sat = D_LO;
    end else begin
      d_sat = d_ext;
    end
  end

  assign ready     = !valid_r || !q_full;
  assign q_push    = valid_r && !q_full;
  assign valid_nxt = accept ? 1'b1 : (q_full ? valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Stage register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= req_type;
      range_r <= on_screen;
      prod_r  <= prod_full[AW-1:0];
      x_r     <= x_coord;
      depth_r <= d_sat[DEPTH_BITS-1:0];
    end
  end

  // Linear index y * w + x
  assign idx_sum      = 21'(prod_r) + 21'(x_r);
  assign cmd_idx      = idx_sum[AW-1:0];
  assign cmd_req      = req_r;
  assign cmd_in_range = range_r;
  assign cmd_depth    = depth_r;

endmodule

`default_nettype wire

// ===== src/dtpb_back.sv =====
// Back end: pixel store with read-test-write and a clearing sweep.
`default_nettype none

module dtpb_back #(
  parameter int DEPTH_BITS = dtpb_pkg::DEPTH_BITS_DEF,
  parameter int AW         = 15,
  parameter int STORE_SIZE = 32768
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cmd_empty,
  input  wire logic [1:0]              cmd_req,
  input  wire logic                    cmd_in_range,
  input  wire logic [AW-1:0]           cmd_idx,
  input  wire logic signed [DEPTH_BITS-1:0] cmd_depth,
  output logic                         cmd_pop,
  input  wire logic [3:0]              pen_color,
  input  wire logic                    res_full,
  output logic                         res_push,
  output dtpb_pkg::result_t            res,
  output logic                         init_busy
);
  import dtpb_pkg::*;

  localparam int MW = DEPTH_BITS + 5;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);

  // Entry: {written, color, depth}
  logic [MW-1:0] mem [STORE_SIZE];
  logic [MW-1:0] rd_r;

  back_state_t state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic          sweep_item_r, sweep_item_nxt;
  logic [1:0]    op_req_r;
  logic          op_range_r;
  logic [AW-1:0] op_idx_r;
  logic signed [DEPTH_BITS-1:0] op_depth_r;

  logic          start, sweep_last;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic          st_written;
  logic [3:0]    st_color;
  logic signed [DEPTH_BITS-1:0] st_depth;

  assign start      = (state_r == BK_IDLE) && !cmd_empty && !res_full;
  assign sweep_last = (sweep_r == LAST_ADDR);
  assign init_busy  = (state_r == BK_SWEEP) && !sweep_item_r;
  assign st_written = rd_r[MW-1];
  assign st_color   = rd_r[MW-2 -: 4];
  assign st_depth   = rd_r[DEPTH_BITS-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_SWEEP: begin
        if (sweep_last) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (start) state_nxt = (cmd_req == REQ_CLEAR) ? BK_SWEEP : BK_EXEC;
      end
      BK_EXEC: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs: store write, queue pop, result beat
  always_comb begin
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = '0;
    res_push  = 1'b0;
    res       = '0;
    case (state_r)
      BK_SWEEP: begin
        mem_we   = 1'b1;
        res_push = sweep_last && sweep_item_r;
      end
      BK_IDLE: begin
        cmd_pop = start;
      end
      BK_EXEC: begin
        res_push = 1'b1;
        if (op_req_r == REQ_PLOT) begin
          res.in_range = op_range_r;
          if (op_range_r && (st_depth == '0 || op_depth_r > st_depth)) begin
            mem_we           = 1'b1;
            mem_waddr        = op_idx_r;
            mem_wdata        = {1'b1, pen_color, op_depth_r};
            res.plot_written = 1'b1;
          end
        end else if (op_req_r == REQ_READ) begin
          res.in_range = op_range_r;
          if (op_range_r && st_written) begin
            res.attribute = {st_color, st_color};
          end
        end
      end
      default: ;
    endcase
  end

  // Sweep address and whether the sweep answers a clear beat
  always_comb begin
    sweep_nxt      = sweep_r;
    sweep_item_nxt = sweep_item_r;
    if (state_r == BK_SWEEP) begin
      sweep_nxt = sweep_last ? '0 : sweep_r + 1'b1;
      if (sweep_last) sweep_item_nxt = 1'b0;
    end else if (start && cmd_req == REQ_CLEAR) begin
      sweep_item_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_SWEEP;
      sweep_r      <= '0;
      sweep_item_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      sweep_item_r <= sweep_item_nxt;
    end
  end

  // Operation latched at pop
  always_ff @(posedge clk) begin
    if (start) begin
      op_req_r   <= cmd_req;
      op_range_r <= cmd_in_range;
      op_idx_r   <= cmd_idx;
      op_depth_r <= cmd_depth;
    end
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Store read port, registered
  always_ff @(posedge clk) begin
    rd_r <= mem[cmd_idx];
  end

endmodule

`default_nettype wire

// ===== src/depth_tested_pixel_buffer_top.sv =====
// Depth-tested pixel buffer: config registers, front, queues and store back end.
// The back end handles one plot or read at a time: it reads the store as it pops the
// command, then tests and writes in BK_EXEC before it can pop the next one.
// A clear zeroes all MAX_WIDTH*MAX_HEIGHT store entries (32768 by default) in the store sweep.
// Reset (rst_n low, synchronous) runs the same sweep; in_full stays high until it ends.
`default_nettype none

module depth_tested_pixel_buffer_top #(
  parameter int MAX_WIDTH  = dtpb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtpb_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dtpb_pkg::DEPTH_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [9:0]         in_x_coord,
  input  wire logic [9:0]         in_y_coord,
  input  wire logic signed [15:0] in_depth_in,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic                    out_plot_written,
  output logic [7:0]              out_attribute,
  output logic                    out_in_range,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [8:0]         cfg_data
);
  import dtpb_pkg::*;

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int CMDW = 3 + AW + DEPTH_BITS;
  localparam int RESW = $bits(result_t);

  logic [8:0] view_width_r;
  logic [7:0] view_height_r;
  logic [3:0] pen_color_r;

  logic front_ready, accept, init_busy;
  logic cq_push, cq_full, cq_pop, cq_empty;
  logic [CMDW-1:0] cq_din, cq_dout;
  logic [1:0]      f_req, b_req;
  logic            f_range, b_range;
  logic [AW-1:0]   f_idx, b_idx;
  logic signed [DEPTH_BITS-1:0] f_depth, b_depth;
  logic    rq_push, rq_full;
  result_t res, res_head;

  // Configuration registers; a zero brush write is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_width_r  <= VIEW_WIDTH_RST;
      view_height_r <= VIEW_HEIGHT_RST;
      pen_color_r   <= PEN_COLOR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VIEW_WIDTH:  view_width_r  <= cfg_data;
        CFG_VIEW_HEIGHT: view_height_r <= cfg_data[7:0];
        CFG_PEN_COLOR: begin
          if (cfg_data[3:0] != 4'd0) pen_color_r <= cfg_data[3:0];
        end
        default: ;
      endcase
    end
  end

  assign in_full = !front_ready || init_busy;
  assign accept  = in_push && !in_full;

  dtpb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .DEPTH_BITS(DEPTH_BITS),
    .AW        (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .req_type     (in_req_type),
    .x_coord      (in_x_coord),
    .y_coord      (in_y_coord),
    .depth_in     (in_depth_in),
    .view_width   (view_width_r),
    .view_height  (view_height_r),
    .ready        (front_ready),
    .q_full       (cq_full),
    .q_push       (cq_push),
    .cmd_req      (f_req),
    .cmd_in_range (f_range),
    .cmd_idx      (f_idx),
    .cmd_depth    (f_depth)
  );

  // Command queue between front and back
  assign cq_din = {f_req, f_range, f_idx, f_depth};
  assign {b_req, b_range, b_idx, b_depth} = cq_dout;

  dtpb_fifo #(
    .WIDTH(CMDW),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cq_push),
    .din  (cq_din),
    .full (cq_full),
    .pop  (cq_pop),
    .dout (cq_dout),
    .empty(cq_empty)
  );

  dtpb_back #(
    .DEPTH_BITS(DEPTH_BITS),
    .AW        (AW),
    .STORE_SIZE(STORE_SIZE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty   (cq_empty),
    .cmd_req     (b_req),
    .cmd_in_range(b_range),
    .cmd_idx     (b_idx),
    .cmd_depth   (b_depth),
    .cmd_pop     (cq_pop),
    .pen_color   (pen_color_r),
    .res_full    (rq_full),
    .res_push    (rq_push),
    .res         (res),
    .init_busy   (init_busy)
  );

  // Result queue
  dtpb_fifo #(
    .WIDTH(RESW),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (rq_push),
    .din  (res),
    .full (rq_full),
    .pop  (out_pop),
    .dout (res_head),
    .empty(out_empty)
  );

  assign out_plot_written = res_head.plot_written;
  assign out_attribute    = res_head.attribute;
  assign out_in_range     = res_head.in_range;

endmodule

`default_nettype wire

// ===== src/dtpb_checker.sv =====
// Port-level checks for the depth-tested pixel buffer, bound to the top level.
`default_nettype none

module dtpb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_plot_written,
  input wire logic [7:0] out_attribute,
  input wire logic       out_in_range
);

  // Reset starts the store sweep, so no beat is taken right after it
  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("in_full low right after reset");

  // Result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A written plot must have passed the bounds test
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_plot_written) |-> out_in_range)
    else $error("plot written out of range");

  // Attribute is the color in both nibbles
  a_attr_nibbles: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_attribute[7:4] == out_attribute[3:0]))
    else $error("attribute nibbles differ");

  // A written plot result carries no attribute
  a_plot_no_attr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_plot_written) |-> (out_attribute == 8'd0))
    else $error("attribute set on plot result");

endmodule

bind depth_tested_pixel_buffer_top dtpb_checker u_dtpb_checker (.*);

`default_nettype wire
